### rtl/prg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_pkg: shared constants and types for the pixel resolve gamma core
// Holds the default parameters, the scale constant and the pipeline tag type.
// ----------------------------------------------------------------------------
package prg_pkg;

  localparam int ACC_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_LANES     = 3;
  localparam logic [15:0] SCALE_Q8 = 16'd65533;

  // Sideband that travels beside each lane's data.
  typedef struct packed {
    logic valid;
    logic no_weight;
  } prg_tag_t;

endpackage

### rtl/pixel_resolve_gamma_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_resolve_gamma_core: film pixel resolve with gamma 2
// Three channel lanes divide, take the square root and scale in parallel.
// ----------------------------------------------------------------------------
// One pixel is accepted per clock while the output is not stalled. The pipeline
// holds one stage per quotient bit and one per root bit pair in each lane, plus
// setup, root load, scale and merge registers. A stall at the output freezes
// the whole pipeline; in_stall follows out_stall only while the pipeline holds
// a pending transfer at its output.
module pixel_resolve_gamma_core import prg_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] red_sum,
  input  logic [31:0] green_sum,
  input  logic [31:0] blue_sum,
  input  logic [31:0] weight_sum,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic        no_weight
);

  // setup + F div + sqrt load + F+1 sqrt + product
  localparam int DEPTH = 2 * FRAC_BITS + 4;

  logic advance;
  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  logic signed [ACC_WIDTH-1:0] w_s;
  assign w_s = signed'(weight_sum[ACC_WIDTH-1:0]);

  logic [31:0] sums [NUM_LANES];
  assign sums[0] = red_sum;
  assign sums[1] = green_sum;
  assign sums[2] = blue_sum;

  logic [7:0] lane_code [NUM_LANES];

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    prg_lane #(.ACC_WIDTH(ACC_WIDTH), .FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .advance(advance),
      .sum    (signed'(sums[l][ACC_WIDTH-1:0])),
      .weight (w_s),
      .code   (lane_code[l])
    );
  end

  prg_tag_t tag_q [DEPTH];

  always_ff @(posedge clk) begin
    if (advance) begin
      tag_q[0].no_weight <= (w_s <= 0);
      for (int k = 1; k < DEPTH; k++) tag_q[k].no_weight <= tag_q[k-1].no_weight;
    end
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) tag_q[k].valid <= 1'b0;
    end else if (advance) begin
      tag_q[0].valid <= in_valid;
      for (int k = 1; k < DEPTH; k++) tag_q[k].valid <= tag_q[k-1].valid;
    end
  end

  prg_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .tag      (tag_q[DEPTH-1]),
    .lane_code(lane_code),
    .out_valid(out_valid),
    .red_out  (red_out),
    .green_out(green_out),
    .blue_out (blue_out),
    .no_weight(no_weight)
  );

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(red_out))
    else $error("result changed while stalled");
  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && no_weight |-> red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("black pixel has nonzero channel");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

### rtl/prg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_lane: one color channel of the resolve pipeline
// Clamped restoring division, bit-pair square root and Q8 scaling, one
// step per pipeline stage, with a shared advance enable.
// ----------------------------------------------------------------------------
module prg_lane import prg_pkg::*; #(
  parameter int ACC_WIDTH = ACC_WIDTH_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        advance,
  input  logic signed [ACC_WIDTH-1:0] sum,
  input  logic signed [ACC_WIDTH-1:0] weight,
  output logic [7:0]                  code
);

  localparam int F  = FRAC_BITS;
  localparam int RW = ACC_WIDTH + 1;     // remainder width (rem < 2*den)
  localparam int SB = 2 * F + 2;         // sqrt operand width
  localparam int RS = F + 2;             // sqrt root width
  localparam int NS = F + 1;             // sqrt iterations (bit pairs)

  // Front stage: classify and set up the divider.
  logic [RW-1:0] rem_q   [0:F];
  logic [RW-1:0] den_q   [0:F];
  logic [F:0]    quo_q   [0:F];
  logic          sat_q   [0:F];

  always_ff @(posedge clk) begin
    if (advance) begin
      den_q[0] <= RW'(unsigned'(weight));
      quo_q[0] <= '0;
      if (sum <= 0) begin
        rem_q[0] <= '0;
        sat_q[0] <= 1'b0;
      end else begin
        rem_q[0] <= RW'(unsigned'(sum));
        sat_q[0] <= (sum >= weight);
      end
    end
  end

  // Division stages: one quotient bit each.
  for (genvar i = 0; i < F; i++) begin : g_div
    logic [RW-1:0] shifted;
    assign shifted = {rem_q[i][RW-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (advance) begin
        den_q[i+1] <= den_q[i];
        sat_q[i+1] <= sat_q[i];
        if (shifted >= den_q[i]) begin
          rem_q[i+1] <= shifted - den_q[i];
          quo_q[i+1] <= {quo_q[i][F-1:0], 1'b1};
        end else begin
          rem_q[i+1] <= shifted;
          quo_q[i+1] <= {quo_q[i][F-1:0], 1'b0};
        end
      end
    end
  end

  // Square root stages, operand q * 2^F.
  logic [SB-1:0] rad_q  [0:NS];
  logic [RS-1:0] root_q [0:NS];

  always_ff @(posedge clk) begin
    if (advance) begin
      rad_q[0]  <= sat_q[F] ? SB'(1) << (2 * F) : SB'({quo_q[F], {F{1'b0}}});
      root_q[0] <= '0;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sqrt
    localparam int P = 2 * (NS - 1 - j);
    logic [SB-1:0] trial;
    assign trial = SB'({root_q[j], 2'b01}) << P;
    always_ff @(posedge clk) begin
      if (advance) begin
        if (rad_q[j] >= trial) begin
          rad_q[j+1]  <= rad_q[j] - trial;
          root_q[j+1] <= {root_q[j][RS-2:0], 1'b1};
        end else begin
          rad_q[j+1]  <= rad_q[j];
          root_q[j+1] <= {root_q[j][RS-2:0], 1'b0};
        end
      end
    end
  end

  // Scale by 255.99 and take the top byte.
  logic [RS+15:0] prod;
  always_ff @(posedge clk) begin
    if (advance) prod <= root_q[NS] * SCALE_Q8;
  end
  assign code = prod[F+15:F+8];

endmodule

### rtl/prg_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prg_merge: output stage of the resolve pipeline
// Combines the lane codes with the weight flag and holds the result register.
// ----------------------------------------------------------------------------
module prg_merge import prg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  prg_tag_t   tag,
  input  logic [7:0] lane_code [NUM_LANES],
  output logic       out_valid,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic       no_weight
);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= tag.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      no_weight <= tag.no_weight;
      red_out   <= tag.no_weight ? 8'd0 : lane_code[0];
      green_out <= tag.no_weight ? 8'd0 : lane_code[1];
      blue_out  <= tag.no_weight ? 8'd0 : lane_code[2];
    end
  end

endmodule

### test/pixel_resolve_gamma_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_resolve_gamma_core_test: self-checking bench for the pixel resolve core
// Drives directed and random pixels through the valid/stall handshake under
// several idle patterns, predicts each resolved pixel and compares in order.
// ----------------------------------------------------------------------------
module pixel_resolve_gamma_core_test import prg_pkg::*;;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int LATENCY = 2 * FRAC + 5;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       dark;
  } pixel_t;

  // Division, clamp, square root and scale for one channel.
  function automatic logic [7:0] gamma_channel(logic signed [31:0] sum,
                                               logic signed [31:0] weight);
    longint q;
    longint s;
    longint n;
    longint bit_v;
    longint product;
    if (sum <= 0) q = 0;
    else if (sum >= weight) q = longint'(1) << FRAC;
    else q = (longint'(sum) << FRAC) / longint'(weight);
    n = q << FRAC;
    s = 0;
    bit_v = longint'(1) << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= s + bit_v) begin
        n = n - (s + bit_v);
        s = (s >> 1) + bit_v;
      end else begin
        s = s >> 1;
      end
      bit_v = bit_v >> 2;
    end
    product = s * longint'(SCALE_Q8);
    return 8'(product >> (FRAC + 8));
  endfunction

  function automatic pixel_t resolve_pixel(logic [31:0] r, logic [31:0] g,
                                           logic [31:0] b, logic [31:0] w);
    pixel_t p;
    p = '0;
    if ($signed(w) <= 0) begin
      p.dark = 1'b1;
    end else begin
      p.red   = gamma_channel(r, w);
      p.green = gamma_channel(g, w);
      p.blue  = gamma_channel(b, w);
    end
    return p;
  endfunction

  class pixel_scoreboard;
    pixel_t pending[$];
    int mismatches;

    function void note_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                             logic [31:0] w);
      pending.push_back(resolve_pixel(r, g, b, w));
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected pixel %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"Pixel mismatch: expected r=%0d g=%0d b=%0d nw=%0d, ",
                    "got r=%0d g=%0d b=%0d nw=%0d"},
                   want.red, want.green, want.blue, want.dark,
                   got.red, got.green, got.blue, got.dark);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] red_sum = '0, green_sum = '0, blue_sum = '0, weight_sum = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red_out, green_out, blue_out;
  logic no_weight;

  pixel_scoreboard board = new();
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_off_cycles = 0;
  int quiet_cycles = 0;

  pixel_resolve_gamma_core dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) board.note_pixel(red_sum, green_sum, blue_sum, weight_sum);
      if (out_valid && !out_stall)
        board.check_pixel({red_out, green_out, blue_out, no_weight});
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold-off when requested.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(65536);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_pixel(logic [31:0] r, logic [31:0] g, logic [31:0] b,
                            logic [31:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    red_sum    <= r;
    green_sum  <= g;
    blue_sum   <= b;
    weight_sum <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random(int count);
    logic [31:0] w;
    for (int i = 0; i < count; i++) begin
      // Mostly positive weights so the divide and root paths are exercised.
      w = ($urandom_range(9) == 0) ? pick_value() : $urandom_range(32'h7fff_ffff, 1);
      if ($urandom_range(1)) w = $urandom_range(32'h0010_0000, 1);
      if ($urandom_range(2) == 0)
        send_pixel(pick_value(), pick_value(), pick_value(), w);
      else
        send_pixel($urandom_range(w), $urandom_range(w), $urandom_range(w), w);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, non-positive weights, zero and saturating channels.
    send_pixel(32'h0, 32'h0, 32'h0, 32'h0);
    send_pixel(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
    send_pixel(32'h1, 32'h1, 32'h1, 32'hffff_ffff);
    send_pixel(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'h7fff_ffff);
    send_pixel(32'h7fff_fffe, 32'h1, 32'hffff_ffff, 32'h7fff_ffff);
    send_pixel(32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 32'h0001_0000);
    send_pixel(32'h0000_0001, 32'h0000_ffff, 32'h0002_0000, 32'h0001_0000);
    send_pixel(32'h1, 32'h0, 32'h2, 32'h1);
    send_pixel(32'h5555_5555, 32'haaaa_aaaa, 32'h1234_5678, 32'h7000_0000);
    send_pixel(32'h0000_0100, 32'h0000_0001, 32'h0000_00ff, 32'h0000_0101);
    drain();

    send_idle_pct = 0;  stall_pct = 0;  send_random(400);
    send_idle_pct = 67; stall_pct = 0;  send_random(350);
    send_idle_pct = 0;  stall_pct = 67; send_random(350);
    send_idle_pct = 13; stall_pct = 13; send_random(350);
    // Long receiver hold-off while the sender keeps offering pixels.
    send_idle_pct = 0;  stall_pct = 0;
    hold_off_cycles <= 200;
    send_random(300);
    drain();
    send_random(60);

    drain();
    repeat (LATENCY + 10) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
